// ===== sv/trc_pkg.sv =====
// Shared types, codes and sizes for the TCP redirect connection tracker.
// Used by trc_cam and tcp_redirect_conntrack; no dependencies of its own.
package trc_pkg;

    // Table geometry
    localparam int TableDepth = 64;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int PortW      = 16;
    localparam int IpW        = 32;
    localparam int EntryW     = IpW + PortW;

    // Configuration
    localparam int CfgIdxW = 1;
    localparam int CfgW    = 16;
    localparam logic [CfgIdxW-1:0] RegRelayPort = 1'd0;
    localparam logic [CfgIdxW-1:0] RegExcludeEn = 1'd1;
    localparam logic [PortW-1:0]   RelayPortReset = 16'd34010;

    // Commands
    localparam logic CmdHeader = 1'b0;
    localparam logic CmdLookup = 1'b1;

    // Result actions
    localparam logic [1:0] ActPass     = 2'd0;
    localparam logic [1:0] ActReinject = 2'd1;
    localparam logic [1:0] ActRewrite  = 2'd2;

    // Table update operations
    localparam logic [1:0] CamNop   = 2'd0;
    localparam logic [1:0] CamSet   = 2'd1;
    localparam logic [1:0] CamClear = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IdxW-1:0]  idx;
        logic [PortW-1:0] key;
    } cam_update_t;

    typedef struct packed {
        logic            hit_a;
        logic [IdxW-1:0] idx_a;
        logic            hit_b;
        logic [IdxW-1:0] idx_b;
        logic            free_ok;
        logic [IdxW-1:0] free_idx;
    } cam_result_t;

    typedef struct packed {
        logic             cmd;
        logic             outbound;
        logic [IpW-1:0]   src_ip;
        logic [IpW-1:0]   dst_ip;
        logic [PortW-1:0] sport;
        logic [PortW-1:0] dport;
        logic             fin_or_rst;
        logic             owner_target;
        logic             owner_excluded;
    } item_t;

    // Index of the lowest set bit (zero when none is set)
    function automatic logic [IdxW-1:0] first_set(input logic [TableDepth-1:0] v);
        logic [IdxW-1:0] idx;
        idx = '0;
        for (int i = TableDepth - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IdxW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== sv/trc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/trc_cam.sv =====
// Key store of the connection table: valid bits and client-port keys with
// two parallel searches and a free-slot finder. Depends on trc_pkg.
module trc_cam (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [trc_pkg::PortW-1:0]  key_a,
    input  logic [trc_pkg::PortW-1:0]  key_b,
    input  trc_pkg::cam_update_t       upd,
    output trc_pkg::cam_result_t       res
);
    import trc_pkg::*;

    logic [TableDepth-1:0] valid_reg;
    logic [PortW-1:0]      key_reg [TableDepth];
    logic [TableDepth-1:0] hit_a;
    logic [TableDepth-1:0] hit_b;

    // per-entry compare against both search keys
    always_comb
    begin
        for (int i = 0; i < TableDepth; i++)
        begin
            hit_a[i] = valid_reg[i] && (key_reg[i] == key_a);
            hit_b[i] = valid_reg[i] && (key_reg[i] == key_b);
        end
    end

    // priority encode: lowest matching / lowest free entry
    always_comb
    begin
        res.hit_a    = |hit_a;
        res.idx_a    = first_set(hit_a);
        res.hit_b    = |hit_b;
        res.idx_b    = first_set(hit_b);
        res.free_ok  = ~&valid_reg;
        res.free_idx = first_set(~valid_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            unique case (upd.op)
                CamSet:   valid_reg[upd.idx] <= 1'b1;
                CamClear: valid_reg[upd.idx] <= 1'b0;
                default:  ;
            endcase
        end
    end

    // keys, written only on a new entry
    always_ff @(posedge clk)
    begin
        if (upd.op == CamSet)
        begin
            key_reg[upd.idx] <= upd.key;
        end
    end

    // a new entry only ever lands in a free slot
    a_set_free: assert property (@(posedge clk) disable iff (!rst_n)
        upd.op == CamSet |-> !valid_reg[upd.idx])
        else $error("entry set over a live entry");

    // only live entries get freed
    a_clear_live: assert property (@(posedge clk) disable iff (!rst_n)
        upd.op == CamClear |-> valid_reg[upd.idx])
        else $error("freeing an entry that is not valid");

    // a stored key is found by the next search for it
    a_set_hit: assert property (@(posedge clk) disable iff (!rst_n)
        upd.op == CamSet && key_a == upd.key && $stable(key_a) |=>
            ($past(upd.key) != key_a) || res.hit_a)
        else $error("stored key not found on next search");

endmodule

// ===== sv/tcp_redirect_conntrack.sv =====
// Top level of the TCP redirect connection tracker: input register, table
// search and decision, result register. Depends on trc_pkg, trc_cam, trc_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one parsed TCP/IPv4 header
//   (cmd 0) or one relay-side lookup by client port (cmd 1) per word.
//   Output channel (out_valid / out_stall) gives exactly one result word per
//   input word, in order.
//   Path: a word accepted into the input register moves to the result
//   register; the search, the decision and the memory read all land there.
//   Throughput: one word per cycle unless out_stall holds a result; the key
//   compare over all table entries and the single read port of the destination
//   memory both run once per cycle, and a table update is seen by the very next word.
//   Stall: a result held by out_stall freezes both registers and raises
//   in_stall in the same cycle; bubbles move freely otherwise.
//   Reset: all table entries are freed, relay_port returns to 34010 and
//   exclude_enable to 0; the block takes words in the first cycle after
//   reset. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next edge; the user makes them only while the block is empty, as the block does not enforce it.
module tcp_redirect_conntrack (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_we,
    input  logic [trc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [trc_pkg::CfgW-1:0]     cfg_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic                         outbound,
    input  logic [trc_pkg::IpW-1:0]      src_ip,
    input  logic [trc_pkg::IpW-1:0]      dst_ip,
    input  logic [trc_pkg::PortW-1:0]    sport,
    input  logic [trc_pkg::PortW-1:0]    dport,
    input  logic                         fin_or_rst,
    input  logic                         owner_target,
    input  logic                         owner_excluded,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   action,
    output logic                         out_outbound,
    output logic [trc_pkg::IpW-1:0]      out_src_ip,
    output logic [trc_pkg::IpW-1:0]      out_dst_ip,
    output logic [trc_pkg::PortW-1:0]    out_src_port,
    output logic [trc_pkg::PortW-1:0]    out_dst_port,
    output logic                         new_flow,
    output logic                         table_full,
    output logic                         found,
    output logic [trc_pkg::IpW-1:0]      orig_ip,
    output logic [trc_pkg::PortW-1:0]    orig_port
);
    import trc_pkg::*;

    // configuration registers
    logic [PortW-1:0] relay_port_reg;
    logic             exclude_en_reg;

    // pipeline control
    logic advance;
    logic s1_fire;
    logic s1_valid_reg;
    logic out_valid_reg;

    // stage 1: input register
    item_t item_reg;
    item_t item_in;

    // table interface
    cam_result_t      cam_res;
    cam_update_t      cam_upd;
    cam_update_t      upd_c;
    logic [IdxW-1:0]  rd_idx_c;
    logic [EntryW-1:0] ram_rdata;

    // stage-1 decision
    logic [1:0]       act_c;
    logic             o_out_c;
    logic [IpW-1:0]   o_sip_c;
    logic [IpW-1:0]   o_dip_c;
    logic [PortW-1:0] o_sport_c;
    logic [PortW-1:0] o_dport_c;
    logic             newf_c;
    logic             full_c;
    logic             found_c;
    logic             use_port_c;

    // result registers
    logic [1:0]       act_reg;
    logic             o_out_reg;
    logic [IpW-1:0]   o_sip_reg;
    logic [IpW-1:0]   o_dip_reg;
    logic [PortW-1:0] o_sport_reg;
    logic [PortW-1:0] o_dport_reg;
    logic             newf_reg;
    logic             full_reg;
    logic             found_reg;
    logic             use_port_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_port_reg <= RelayPortReset;
            exclude_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegRelayPort: relay_port_reg <= cfg_data;
                RegExcludeEn: exclude_en_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // both registers move unless a finished result is held
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign s1_fire  = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // input register
    always_comb
    begin
        item_in.cmd            = cmd;
        item_in.outbound       = outbound;
        item_in.src_ip         = src_ip;
        item_in.dst_ip         = dst_ip;
        item_in.sport          = sport;
        item_in.dport          = dport;
        item_in.fin_or_rst     = fin_or_rst;
        item_in.owner_target   = owner_target;
        item_in.owner_excluded = owner_excluded;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            item_reg <= item_in;
        end
    end

    // key store: search a = source port, search b = destination port
    trc_cam u_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .key_a (item_reg.sport),
        .key_b (item_reg.dport),
        .upd   (cam_upd),
        .res   (cam_res)
    );

    // decision for the word in stage 1
    always_comb
    begin
        act_c      = ActPass;
        o_out_c    = item_reg.outbound;
        o_sip_c    = item_reg.src_ip;
        o_dip_c    = item_reg.dst_ip;
        o_sport_c  = item_reg.sport;
        o_dport_c  = item_reg.dport;
        newf_c     = 1'b0;
        full_c     = 1'b0;
        found_c    = 1'b0;
        use_port_c = 1'b0;
        rd_idx_c   = cam_res.idx_a;
        upd_c.op   = CamNop;
        upd_c.idx  = cam_res.idx_a;
        upd_c.key  = item_reg.sport;

        if (item_reg.cmd == CmdLookup)
        begin
            // relay lookup by client port
            o_out_c   = 1'b0;
            o_sip_c   = '0;
            o_dip_c   = '0;
            o_sport_c = '0;
            o_dport_c = '0;
            found_c   = cam_res.hit_a;
        end
        else if (item_reg.outbound)
        begin
            if (exclude_en_reg && item_reg.owner_excluded)
            begin
                act_c = ActPass;
            end
            else if (item_reg.sport == relay_port_reg)
            begin
                // relay reply: restore original destination port
                rd_idx_c   = cam_res.idx_b;
                use_port_c = cam_res.hit_b;
                o_sip_c    = item_reg.dst_ip;
                o_dip_c    = item_reg.src_ip;
                o_out_c    = 1'b0;
                act_c      = ActRewrite;
                if (item_reg.fin_or_rst && cam_res.hit_b)
                begin
                    upd_c.op  = CamClear;
                    upd_c.idx = cam_res.idx_b;
                end
            end
            else if (cam_res.hit_a || item_reg.owner_target)
            begin
                if (cam_res.hit_a)
                begin
                    // tracked flow, freed on FIN/RST
                    if (item_reg.fin_or_rst)
                    begin
                        upd_c.op  = CamClear;
                        upd_c.idx = cam_res.idx_a;
                    end
                end
                else if (cam_res.free_ok)
                begin
                    // new targeted flow
                    upd_c.op  = CamSet;
                    upd_c.idx = cam_res.free_idx;
                    newf_c    = 1'b1;
                end
                else
                begin
                    full_c = 1'b1;
                end
                o_dport_c = relay_port_reg;
                o_sip_c   = item_reg.dst_ip;
                o_dip_c   = item_reg.src_ip;
                o_out_c   = 1'b0;
                act_c     = ActRewrite;
            end
        end
        else if (item_reg.dport == relay_port_reg)
        begin
            act_c = ActReinject;
        end
    end

    // table updates only when the word leaves stage 1
    always_comb
    begin
        cam_upd    = upd_c;
        cam_upd.op = s1_fire ? upd_c.op : CamNop;
    end

    // original destinations, indexed like the key store; the read data
    // lands with the result register and holds with it
    trc_ram #(
        .Width (EntryW),
        .Depth (TableDepth)
    ) u_dest_ram (
        .clk   (clk),
        .we    (s1_fire && (upd_c.op == CamSet)),
        .waddr (upd_c.idx),
        .wdata ({item_reg.dst_ip, item_reg.dport}),
        .re    (s1_fire),
        .raddr (rd_idx_c),
        .rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            act_reg      <= act_c;
            o_out_reg    <= o_out_c;
            o_sip_reg    <= o_sip_c;
            o_dip_reg    <= o_dip_c;
            o_sport_reg  <= o_sport_c;
            o_dport_reg  <= o_dport_c;
            newf_reg     <= newf_c;
            full_reg     <= full_c;
            found_reg    <= found_c;
            use_port_reg <= use_port_c;
        end
    end

    // merge in the memory read
    assign out_valid    = out_valid_reg;
    assign action       = act_reg;
    assign out_outbound = o_out_reg;
    assign out_src_ip   = o_sip_reg;
    assign out_dst_ip   = o_dip_reg;
    assign out_src_port = use_port_reg ? ram_rdata[PortW-1:0] : o_sport_reg;
    assign out_dst_port = o_dport_reg;
    assign new_flow     = newf_reg;
    assign table_full   = full_reg;
    assign found        = found_reg;
    assign orig_ip      = found_reg ? ram_rdata[EntryW-1:PortW] : '0;
    assign orig_port    = found_reg ? ram_rdata[PortW-1:0] : '0;

    // a lookup answer never comes with a header action or a new flow
    a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> action == ActPass && !new_flow && !table_full)
        else $error("lookup hit reported on a header word");

    // input stalls only behind a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action)
            && $stable(out_src_ip) && $stable(out_src_port) && $stable(orig_ip))
        else $error("result changed while stalled");

endmodule
